[sv/utf8_to_ascii_sanitizer_defines.svh]
// ============================================================================
// UTF-8 to ASCII sanitizer: assertion macros
// Shared concurrent assertion helpers. Each one samples on clk and is
// disabled while rst_n is low. Defining ASSERT_OFF removes them.
// ============================================================================
`ifndef UTF8_TO_ASCII_SANITIZER_DEFINES_SVH
`define UTF8_TO_ASCII_SANITIZER_DEFINES_SVH

`ifndef ASSERT_OFF

// Property that must hold at every clock edge outside reset.
`define U2A_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition that must never be true at a clock edge outside reset.
`define U2A_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`else

`define U2A_ASSERT(lbl, prop, msg)
`define U2A_NEVER(lbl, cond, msg)

`endif

`endif

[sv/u2a_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// u2a_pkg
// Types, character codes and the code point mapping shared by the front
// decoder and the back end of the UTF-8 to ASCII sanitizer.
// ============================================================================
package u2a_pkg;

    // Printable ASCII characters produced by the mapping.
    localparam logic [6:0] CH_QMARK = 7'h3F;
    localparam logic [6:0] CH_STAR  = 7'h2A;
    localparam logic [6:0] CH_DOT   = 7'h2E;
    localparam logic [6:0] CH_APOS  = 7'h27;
    localparam logic [6:0] CH_COMMA = 7'h2C;
    localparam logic [6:0] CH_QUOTE = 7'h22;
    localparam logic [6:0] CH_DASH  = 7'h2D;
    localparam logic [6:0] CH_SPACE = 7'h20;

    // Code points that the mapping recognizes.
    localparam logic [20:0] CP_PRINT_LO   = 21'h00020;
    localparam logic [20:0] CP_PRINT_HI   = 21'h0007E;
    localparam logic [20:0] CP_NBSP       = 21'h000A0;
    localparam logic [20:0] CP_EN_DASH    = 21'h02013;
    localparam logic [20:0] CP_EM_DASH    = 21'h02014;
    localparam logic [20:0] CP_LSQUO      = 21'h02018;
    localparam logic [20:0] CP_RSQUO      = 21'h02019;
    localparam logic [20:0] CP_SBQUO      = 21'h0201A;
    localparam logic [20:0] CP_SQUO_REV   = 21'h0201B;
    localparam logic [20:0] CP_LDQUO      = 21'h0201C;
    localparam logic [20:0] CP_RDQUO      = 21'h0201D;
    localparam logic [20:0] CP_BDQUO      = 21'h0201E;
    localparam logic [20:0] CP_ELLIPSIS   = 21'h02026;
    localparam logic [20:0] CP_ZW_LO      = 21'h0200B;
    localparam logic [20:0] CP_ZW_HI      = 21'h0200D;
    localparam logic [20:0] CP_VS_LO      = 21'h0FE00;
    localparam logic [20:0] CP_VS_HI      = 21'h0FE0F;
    localparam logic [20:0] CP_BOM        = 21'h0FEFF;
    localparam logic [20:0] CP_SKIN_LO    = 21'h1F3FB;
    localparam logic [20:0] CP_SKIN_HI    = 21'h1F3FF;
    localparam logic [20:0] CP_SYM_LO     = 21'h02600;
    localparam logic [20:0] CP_SYM_HI     = 21'h027BF;
    localparam logic [20:0] CP_EMOJI_LO   = 21'h1F000;
    localparam logic [20:0] CP_EMOJI_HI   = 21'h1FAFF;

    // Reset value of the capacity register and its clamp bounds.
    localparam logic [16:0] LIMIT_RESET = 17'd256;
    localparam logic [16:0] LIMIT_MIN   = 17'd1;
    localparam logic [16:0] LIMIT_MAX   = 17'd65536;

    // Result of mapping one code point: how many copies of ch to emit.
    typedef struct packed {
        logic [1:0] cnt;
        logic [6:0] ch;
    } u2a_map_t;

    // Work handed from the front decoder to the back end for one byte.
    typedef struct packed {
        logic [2:0][6:0] chars;
        logic [1:0]      nchar;
        logic            term;
    } u2a_cmd_t;

    // Map one decoded code point to zero, one or three ASCII characters.
    function automatic u2a_map_t u2a_map_cp(input logic [20:0] cp);
        u2a_map_t m;
        m.cnt = 2'd1;
        m.ch  = CH_QMARK;
        if (cp >= CP_PRINT_LO && cp <= CP_PRINT_HI)
        begin
            m.ch = cp[6:0];
        end
        else if (cp == CP_LSQUO || cp == CP_RSQUO || cp == CP_SQUO_REV)
        begin
            m.ch = CH_APOS;
        end
        else if (cp == CP_SBQUO)
        begin
            m.ch = CH_COMMA;
        end
        else if (cp == CP_LDQUO || cp == CP_RDQUO || cp == CP_BDQUO)
        begin
            m.ch = CH_QUOTE;
        end
        else if (cp == CP_EN_DASH || cp == CP_EM_DASH)
        begin
            m.ch = CH_DASH;
        end
        else if (cp == CP_ELLIPSIS)
        begin
            m.cnt = 2'd3;
            m.ch  = CH_DOT;
        end
        else if (cp == CP_NBSP)
        begin
            m.ch = CH_SPACE;
        end
        else if ((cp >= CP_ZW_LO && cp <= CP_ZW_HI) ||
                 (cp >= CP_VS_LO && cp <= CP_VS_HI) || cp == CP_BOM ||
                 (cp >= CP_SKIN_LO && cp <= CP_SKIN_HI))
        begin
            m.cnt = 2'd0;
        end
        else if ((cp >= CP_SYM_LO && cp <= CP_SYM_HI) ||
                 (cp >= CP_EMOJI_LO && cp <= CP_EMOJI_HI))
        begin
            m.ch = CH_STAR;
        end
        return m;
    endfunction

endpackage

[sv/u2a_front.sv]
`timescale 1ns / 1ps
// ============================================================================
// u2a_front
// UTF-8 front decoder. Takes one byte per cycle while the queue is not full,
// assembles multi-byte sequences and turns each byte into a command listing
// the characters it tries to write and whether it ends the text.
// ============================================================================
`include "utf8_to_ascii_sanitizer_defines.svh"

module u2a_front
    import u2a_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tlast,   // text_end
    input  logic       q_full,
    output logic       q_push,
    output u2a_cmd_t   q_cmd
);

    logic [20:0] part_reg;
    logic [20:0] part_next;
    logic [1:0]  pend_reg;
    logic [1:0]  pend_next;

    logic        accept;
    logic [7:0]  b;
    logic        is_cont;
    logic        malformed;
    logic        do_lead;
    logic [20:0] cont_part;
    u2a_map_t    cont_map;
    logic        lead_emit;
    logic [6:0]  lead_char;
    logic [1:0]  lead_pend;
    logic [20:0] lead_part;
    logic [1:0]  pend_after;
    logic [20:0] part_after;
    logic [2:0][6:0] chars;
    logic [1:0]  n;

    assign b             = s_axis_tdata;
    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Continuation handling for an open sequence.
    assign is_cont   = (b[7:6] == 2'b10);
    assign malformed = (pend_reg != 2'd0) && !is_cont;
    assign do_lead   = (pend_reg == 2'd0) || malformed;
    assign cont_part = {part_reg[14:0], b[5:0]};
    assign cont_map  = u2a_map_cp(cont_part);

    // Lead byte classification.
    always_comb
    begin
        lead_emit = 1'b0;
        lead_char = CH_QMARK;
        lead_pend = 2'd0;
        lead_part = '0;
        if (b[7] == 1'b0)
        begin
            lead_emit = 1'b1;
            if (b >= 8'h20 && b <= 8'h7E)
            begin
                lead_char = b[6:0];
            end
        end
        else if (b[7:5] == 3'b110)
        begin
            lead_pend = 2'd1;
            lead_part = {16'd0, b[4:0]};
        end
        else if (b[7:4] == 4'b1110)
        begin
            lead_pend = 2'd2;
            lead_part = {17'd0, b[3:0]};
        end
        else if (b[7:3] == 5'b11110)
        begin
            lead_pend = 2'd3;
            lead_part = {18'd0, b[2:0]};
        end
        else
        begin
            // Invalid lead byte stands for the replacement character.
            lead_emit = 1'b1;
        end
    end

    // Sequence state after this byte, before the end-of-text flush.
    always_comb
    begin
        if (do_lead)
        begin
            pend_after = lead_pend;
            part_after = lead_part;
        end
        else
        begin
            pend_after = pend_reg - 2'd1;
            part_after = cont_part;
        end
    end

    // Build the character list in emission order.
    always_comb
    begin
        chars = {3{CH_QMARK}};
        n     = 2'd0;
        if (!do_lead && pend_reg == 2'd1)
        begin
            chars = {3{cont_map.ch}};
            n     = cont_map.cnt;
        end
        if (malformed)
        begin
            chars[n] = CH_QMARK;
            n        = n + 2'd1;
        end
        if (do_lead && lead_emit)
        begin
            chars[n] = lead_char;
            n        = n + 2'd1;
        end
        if (s_axis_tlast && pend_after != 2'd0)
        begin
            chars[n] = CH_QMARK;
            n        = n + 2'd1;
        end
    end

    // Bytes with nothing to emit and no text end skip the queue.
    assign q_cmd.chars = chars;
    assign q_cmd.nchar = n;
    assign q_cmd.term  = s_axis_tlast;
    assign q_push      = accept && (n != 2'd0 || s_axis_tlast);

    // Decoder state update.
    always_comb
    begin
        pend_next = pend_reg;
        part_next = part_reg;
        if (accept)
        begin
            if (s_axis_tlast)
            begin
                pend_next = 2'd0;
                part_next = '0;
            end
            else
            begin
                pend_next = pend_after;
                part_next = part_after;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 2'd0;
            part_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
            part_reg <= part_next;
        end
    end

    `U2A_ASSERT(a_end_closes_seq, (accept && s_axis_tlast) |=> (pend_reg == 2'd0), "text end left a sequence open")

endmodule

[sv/u2a_queue.sv]
`timescale 1ns / 1ps
// ============================================================================
// u2a_queue
// Short command queue between the front decoder and the back end, so that
// either side can stall without holding up the other.
// ============================================================================
`include "utf8_to_ascii_sanitizer_defines.svh"

module u2a_queue
    import u2a_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  u2a_cmd_t push_cmd,
    input  logic     pop,
    output logic     full,
    output logic     not_empty,
    output u2a_cmd_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    u2a_cmd_t         slots [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    assign full      = (cnt_reg == FULL_CNT);
    assign not_empty = (cnt_reg != '0);
    assign head      = slots[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Command storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_cmd;
        end
    end

    `U2A_NEVER(a_no_overflow, push && full, "command pushed into a full queue")
    `U2A_NEVER(a_no_underflow, pop && !not_empty, "command popped from an empty queue")

endmodule

[sv/u2a_back.sv]
`timescale 1ns / 1ps
// ============================================================================
// u2a_back
// Back end of the sanitizer. Walks each queued command one character per
// cycle while the output register is free, applies the capacity limit,
// counts written characters and emits the terminator. Holds the capacity
// register and the output register.
`include "utf8_to_ascii_sanitizer_defines.svh"

module u2a_back
    import u2a_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        output_limit_we,
    input  logic [16:0] output_limit_wdata,
    input  logic        q_valid,
    input  u2a_cmd_t    head,
    output logic        pop,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [6:0] out_char, [22:7] total_written, [23] zero
    output logic        m_axis_tuser,   // is_terminator
    output logic        m_axis_tlast    // run_last
);

    logic [16:0] limit_reg;
    logic [15:0] count_reg;
    logic [15:0] count_next;
    logic        stopped_reg;
    logic        stopped_next;
    logic [1:0]  idx_reg;
    logic [1:0]  idx_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [6:0]  out_char_reg;
    logic [15:0] out_total_reg;
    logic        out_term_reg;
    logic        out_last_reg;

    logic [16:0] lim;
    logic [16:0] count_inc;
    logic        fits;
    logic        next_fits;
    logic        in_char;
    logic        more;
    logic        out_free;
    logic        load;
    logic [6:0]  ld_char;
    logic [15:0] ld_total;
    logic        ld_term;
    logic        ld_last;

    // Capacity register; the user must write it only while idle, which the block itself does not enforce.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (output_limit_we)
        begin
            limit_reg <= output_limit_wdata;
        end
    end

    // Clamp the limit to the range the 16-bit count supports.
    always_comb
    begin
        if (limit_reg < LIMIT_MIN)
        begin
            lim = LIMIT_MIN;
        end
        else if (limit_reg > LIMIT_MAX)
        begin
            lim = LIMIT_MAX;
        end
        else
        begin
            lim = limit_reg;
        end
    end

    assign count_inc = {1'b0, count_reg} + 17'd1;
    assign fits      = !stopped_reg && (count_inc < lim);
    assign next_fits = ({2'b00, count_reg} + 18'd2) < {1'b0, lim};
    assign in_char   = idx_reg < head.nchar;
    assign more      = ({1'b0, idx_reg} + 3'd1) < {1'b0, head.nchar};
    assign out_free  = !out_valid_reg || m_axis_tready;

    // At most one result per cycle, while the output register is free, from the command at the head of the queue.
    always_comb
    begin
        count_next   = count_reg;
        stopped_next = stopped_reg;
        idx_next     = idx_reg;
        pop          = 1'b0;
        load         = 1'b0;
        ld_char      = '0;
        ld_total     = count_reg;
        ld_term      = 1'b0;
        ld_last      = 1'b0;
        if (q_valid && out_free)
        begin
            priority if (in_char && fits)
            begin
                load       = 1'b1;
                ld_char    = head.chars[idx_reg];
                ld_total   = count_inc[15:0];
                count_next = count_inc[15:0];
                if (more && next_fits)
                begin
                    idx_next = idx_reg + 2'd1;
                end
                else
                begin
                    // Last character taken, or a remaining one would overflow: stop if so.
                    if (more)
                    begin
                        stopped_next = 1'b1;
                    end
                    if (head.term)
                    begin
                        idx_next = head.nchar;
                    end
                    else
                    begin
                        pop      = 1'b1;
                        idx_next = 2'd0;
                        ld_last  = 1'b1;
                    end
                end
            end
            else if (in_char)
            begin
                // Character blocked by the limit; later ones are too.
                stopped_next = 1'b1;
                pop          = 1'b1;
                idx_next     = 2'd0;
                if (head.term)
                begin
                    load         = 1'b1;
                    ld_term      = 1'b1;
                    ld_last      = 1'b1;
                    count_next   = '0;
                    stopped_next = 1'b0;
                end
            end
            else
            begin
                // Terminator after the characters of the final byte.
                load         = 1'b1;
                ld_term      = 1'b1;
                ld_last      = 1'b1;
                pop          = 1'b1;
                idx_next     = 2'd0;
                count_next   = '0;
                stopped_next = 1'b0;
            end
        end
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            stopped_reg   <= 1'b0;
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            stopped_reg   <= stopped_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_char_reg  <= ld_char;
            out_total_reg <= ld_total;
            out_term_reg  <= ld_term;
            out_last_reg  <= ld_last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_total_reg, out_char_reg};
    assign m_axis_tuser  = out_term_reg;
    assign m_axis_tlast  = out_last_reg;

    `U2A_ASSERT(a_term_clears, (load && ld_term) |=> (count_reg == '0 && !stopped_reg), "terminator did not clear the count")
    `U2A_ASSERT(a_idx_in_range, q_valid |-> (idx_reg <= head.nchar), "character index past the command")

endmodule

[sv/utf8_to_ascii_sanitizer.sv]
`timescale 1ns / 1ps
// ============================================================================
// utf8_to_ascii_sanitizer
// UTF-8 text to printable ASCII converter with a capacity limit.
// ============================================================================
// The block takes one UTF-8 byte per cycle on the input stream while the
// command queue has room, and writes printable ASCII characters on the
// output stream, one result per cycle while the output is ready. The back
// end handles one result at a time, so a byte that yields several results
// (an ellipsis, a malformed sequence, or the terminator at text end) holds
// the back end while the command queue of QUEUE_DEPTH entries keeps the
// input flowing. Bytes with no visible result (an open sequence, a dropped
// code point) never reach the back end. A result passes through the
// command queue and the output register. Output stops for the rest of a
// text once output_limit - 1 characters have been written; the terminator,
// flagged in tuser, carries the final count and clears the count for the
// next text. output_limit may be written only while idle.
// ============================================================================
module utf8_to_ascii_sanitizer
    import u2a_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4  // commands buffered between front and back, 2 or more
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,        // [7:0] in_byte
    input  logic        s_axis_tlast,        // text_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,        // [6:0] out_char, [22:7] total_written, [23] zero
    output logic        m_axis_tuser,        // is_terminator
    output logic        m_axis_tlast,        // run_last
    input  logic        output_limit_we,
    input  logic [16:0] output_limit_wdata
);

    logic     q_full;
    logic     q_push;
    logic     q_pop;
    logic     q_valid;
    u2a_cmd_t q_cmd;
    u2a_cmd_t q_head;

    // Byte decoder.
    u2a_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_cmd         (q_cmd)
    );

    // Command queue.
    u2a_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (q_cmd),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_valid),
        .head      (q_head)
    );

    // Limit, counting and output stage.
    u2a_back u_back
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .output_limit_we    (output_limit_we),
        .output_limit_wdata (output_limit_wdata),
        .q_valid            (q_valid),
        .head               (q_head),
        .pop                (q_pop),
        .m_axis_tvalid      (m_axis_tvalid),
        .m_axis_tready      (m_axis_tready),
        .m_axis_tdata       (m_axis_tdata),
        .m_axis_tuser       (m_axis_tuser),
        .m_axis_tlast       (m_axis_tlast)
    );

endmodule
